### src/signed_integer_to_radix_digits_top_assert.svh
// assertion macros for the radix digit converter checker
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_TOP_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SIRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SIRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sird_pkg.sv
// shared types, constants and tables for the radix digit converter
`timescale 1ns / 1ps

package sird_pkg;

  localparam int WORD_W  = 32;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 5;
  localparam int SYM_W   = 64;
  localparam int IDX_W   = 2;
  localparam int DIG_W   = 4;
  localparam int NSYM    = 16;
  localparam int NDIG    = 32;
  localparam int NDIG_W  = 5;
  localparam int CNT_W   = 6;
  localparam int MAX_BASE = 16;

  // register indexes
  localparam logic [IDX_W-1:0] REG_BASE_LENGTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // reset values of the registers
  localparam logic [LEN_W-1:0] BASE_LENGTH_RST  = 5'd10;
  localparam logic [SYM_W-1:0] SYMBOLS_LOW_RST  = 64'd3978425819141910832;
  localparam logic [SYM_W-1:0] SYMBOLS_HIGH_RST = 64'd17977;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] SYM_MIN    = 8'd48;

  // datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic fix;
    logic emit_sign;
    logic emit_digit;
  } sird_cmd_t;

  // datapath status
  typedef struct packed {
    logic base_ok;
    logic div_done;
    logic neg;
    logic out_free;
    logic last_digit;
  } sird_sts_t;

  // floor(2^32 / d) for the supported radixes
  function automatic logic [WORD_W-1:0] recip(input logic [LEN_W-1:0] d);
    logic [WORD_W-1:0] r;
    unique case (d)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/sird_ctrl.sv
// controller state machine for the radix digit converter
`timescale 1ns / 1ps

module sird_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sird_pkg::sird_sts_t sts,
  output sird_pkg::sird_cmd_t cmd
);
  import sird_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        // a word with an invalid symbol set is taken and dropped
        if (in_valid && sts.base_ok) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        if (sts.div_done) begin
          state_nxt = sts.neg ? S_SIGN : S_EMIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.last_digit) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/sird_dp.sv
// datapath: config registers, base check, reciprocal divider, digit buffer, output word
`timescale 1ns / 1ps

module sird_dp #(
  parameter int MAX_BASE = sird_pkg::MAX_BASE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sird_pkg::IDX_W-1:0]          cfg_index,
  input  logic [sird_pkg::SYM_W-1:0]          cfg_wdata,
  input  logic signed [sird_pkg::WORD_W-1:0]  in_value,
  input  sird_pkg::sird_cmd_t                 cmd,
  output sird_pkg::sird_sts_t                 sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sird_pkg::CHAR_W-1:0]         out_character,
  output logic                                out_last
);
  import sird_pkg::*;

  logic [LEN_W-1:0]  len_r;
  logic [SYM_W-1:0]  sym_lo_r;
  logic [SYM_W-1:0]  sym_hi_r;
  logic [CHAR_W-1:0] sym [NSYM];
  logic              base_ok;

  logic [WORD_W-1:0] mag_r;
  logic [WORD_W-1:0] mag_nxt;
  logic [WORD_W-1:0] qe_r;
  logic              neg_r;
  logic [CNT_W-1:0]  nd_r;
  logic [DIG_W-1:0]  dig_r [NDIG];

  logic [2*WORD_W-1:0]   recip_prod;
  logic [WORD_W+LEN_W-1:0] back_prod;
  logic [WORD_W-1:0]     rem0;
  logic                  rem_ge;
  logic [WORD_W-1:0]     q_fix;
  logic [WORD_W-1:0]     rem_fix;
  logic [NDIG_W-1:0]     rd_idx;
  logic [CNT_W-1:0]      nd_dec;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= BASE_LENGTH_RST;
      sym_lo_r <= SYMBOLS_LOW_RST;
      sym_hi_r <= SYMBOLS_HIGH_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_LENGTH) begin
        len_r <= cfg_wdata[LEN_W-1:0];
      end
      if (cfg_index == REG_SYMBOLS_LOW) begin
        sym_lo_r <= cfg_wdata;
      end
      if (cfg_index == REG_SYMBOLS_HIGH) begin
        sym_hi_r <= cfg_wdata;
      end
    end
  end

  // symbol table as bytes
  always_comb begin
    for (int i = 0; i < NSYM / 2; i++) begin
      sym[i]            = sym_lo_r[i*CHAR_W +: CHAR_W];
      sym[i + NSYM / 2] = sym_hi_r[i*CHAR_W +: CHAR_W];
    end
  end

  // symbol set check: length, range of each symbol, no repeats
  always_comb begin
    base_ok = (len_r >= LEN_W'(2)) && (len_r <= LEN_W'(MAX_BASE));
    for (int i = 0; i < NSYM; i++) begin
      if (LEN_W'(i) < len_r) begin
        if (sym[i] < SYM_MIN || sym[i][CHAR_W-1]) begin
          base_ok = 1'b0;
        end
        for (int j = i + 1; j < NSYM; j++) begin
          if (LEN_W'(j) < len_r && sym[i] == sym[j]) begin
            base_ok = 1'b0;
          end
        end
      end
    end
  end

  // estimate quotient by reciprocal, then one correction step
  assign recip_prod = {{WORD_W{1'b0}}, mag_r} * {{WORD_W{1'b0}}, recip(len_r)};
  assign back_prod  = (WORD_W + LEN_W)'(qe_r) * (WORD_W + LEN_W)'(len_r);
  assign rem0       = mag_r - back_prod[WORD_W-1:0];
  assign rem_ge     = (rem0 >= WORD_W'(len_r));
  assign q_fix      = rem_ge ? (qe_r + WORD_W'(1)) : qe_r;
  assign rem_fix    = rem_ge ? (rem0 - WORD_W'(len_r)) : rem0;

  // magnitude of the input word
  assign mag_nxt = in_value[WORD_W-1] ? (WORD_W'(0) - WORD_W'(in_value)) : WORD_W'(in_value);

  assign nd_dec = nd_r - CNT_W'(1);
  assign rd_idx = nd_dec[NDIG_W-1:0];

  // divider and digit buffer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= mag_nxt;
      neg_r <= in_value[WORD_W-1];
    end
    if (cmd.mul) begin
      qe_r <= recip_prod[2*WORD_W-1:WORD_W];
    end
    if (cmd.fix) begin
      mag_r <= q_fix;
      dig_r[nd_r[NDIG_W-1:0]] <= rem_fix[DIG_W-1:0];
    end
  end

  // digit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nd_r <= '0;
    end else if (cmd.load) begin
      nd_r <= '0;
    end else if (cmd.fix) begin
      nd_r <= nd_r + CNT_W'(1);
    end else if (cmd.emit_digit) begin
      nd_r <= nd_dec;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= sym[dig_r[rd_idx]];
      out_last_r <= (nd_r == CNT_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // status to the controller
  assign sts.base_ok    = base_ok;
  assign sts.div_done   = (q_fix == '0) || (nd_r == CNT_W'(NDIG - 1));
  assign sts.neg        = neg_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.last_digit = (nd_r == CNT_W'(1));

endmodule

### src/signed_integer_to_radix_digits_top.sv
// Signed integer to radix text converter, one character word per output handshake.
// For each digit the reciprocal divider multiplies and then corrects; the words are emitted
// once all digits are done, with a minus sign first for a negative value.
// A new item is taken only once the last word of the one before is in the output register;
// a word that comes with an invalid symbol set is taken and dropped.
// Synchronous active-low reset restores radix 10 and the default symbols.
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_top #(
  parameter int MAX_BASE = sird_pkg::MAX_BASE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sird_pkg::WORD_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sird_pkg::CHAR_W-1:0]         out_character,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  logic [sird_pkg::IDX_W-1:0]          cfg_index,
  input  logic [sird_pkg::SYM_W-1:0]          cfg_wdata
);
  import sird_pkg::*;

  sird_cmd_t cmd;
  sird_sts_t sts;

  // controller
  sird_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  sird_dp #(
    .MAX_BASE (MAX_BASE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

### src/sird_checker.sv
// port-level checker for the radix digit converter, bound to the top level
`timescale 1ns / 1ps
`include "signed_integer_to_radix_digits_top_assert.svh"

module sird_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sird_pkg::CHAR_W-1:0]   out_character,
  input logic                          out_last
);
  import sird_pkg::*;

  logic              out_stall;
  logic [CHAR_W:0]   out_word;
  logic              char_legal;
  logic              sign_word;

  assign out_stall  = out_valid && !out_ready;
  assign out_word   = {out_character, out_last};
  assign char_legal = (out_character == CHAR_MINUS) ||
                      (out_character >= SYM_MIN && !out_character[CHAR_W-1]);
  assign sign_word  = out_valid && (out_character == CHAR_MINUS);

  // stalled output word holds
  `SIRD_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled word changed")

  // no new input while a conversion still has words to give
  `SIRD_ASSERT_SAME(a_busy, out_valid && !out_last, !in_ready, "input taken mid conversion")

  // characters are the minus sign or a checked symbol
  `SIRD_ASSERT_SAME(a_char_range, out_valid, char_legal, "character out of range")

  // minus sign is always followed by digits
  `SIRD_ASSERT_SAME(a_sign_not_last, sign_word, !out_last, "minus sign marked last")

endmodule

bind signed_integer_to_radix_digits_top sird_checker u_sird_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_character (out_character),
  .out_last      (out_last)
);

### tb/tb.sv
// self-checking testbench for the signed integer to radix text converter
`timescale 1ns / 1ps

module tb;
  import sird_pkg::*;

  // register index with no register behind it
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  // cycles to let the converter finish an item that gives no characters
  localparam int IDLE_WAIT = 150;
  // cycles without any handshake or register write before the run is abandoned
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 336;
  localparam int ITEMS_PER_BASE = 30;
  localparam int ITEMS_BAD_BASE = 6;
  localparam int MAX_REPORTS = 10;
  localparam logic [WORD_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [SYM_W-1:0] HEX_LOW = 64'h3736_3534_3332_3130;
  localparam logic [SYM_W-1:0] HEX_HIGH = 64'h4645_4443_4241_3938;
  localparam logic [CHAR_W-1:0] SYM_TOO_LOW = 8'h2F;
  localparam logic [CHAR_W-1:0] SYM_TOO_HIGH = 8'h80;

  typedef enum int {
    FLAW_SHORT, FLAW_LONG, FLAW_LOW_SYM, FLAW_HIGH_SYM, FLAW_REPEAT, FLAW_NONE
  } base_flaw_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [WORD_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CHAR_W-1:0] out_character;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [SYM_W-1:0] cfg_wdata = '0;

  // register copies the predictor works from
  logic [LEN_W-1:0] cur_len = BASE_LENGTH_RST;
  logic [SYM_W-1:0] cur_low = SYMBOLS_LOW_RST;
  logic [SYM_W-1:0] cur_high = SYMBOLS_HIGH_RST;

  logic [WORD_W-1:0] values_to_send[$];
  text_char_t expected_text[$];
  text_char_t want;
  logic in_taken = 1'b0;
  int send_idle_pct = 33;
  int recv_idle_pct = 51;
  int quiet_cycles = 0;
  int errors = 0;

  signed_integer_to_radix_digits_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // symbol k of the configured table
  function automatic logic [CHAR_W-1:0] symbol_of(input int unsigned k);
    logic [2*SYM_W-1:0] all_syms;
    all_syms = {cur_high, cur_low};
    return all_syms[k*CHAR_W +: CHAR_W];
  endfunction

  // radix in range, symbols from '0' up to 127 and all distinct
  function automatic bit symbol_set_ok();
    int unsigned n;
    n = cur_len;
    if (n < 2 || n > MAX_BASE) return 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (symbol_of(i) < SYM_MIN || symbol_of(i) >= 8'd128) return 1'b0;
      for (int unsigned j = i + 1; j < n; j++)
        if (symbol_of(i) == symbol_of(j)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the characters one value turns into
  function automatic void predict_radix_text(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] mag;
    logic [CHAR_W-1:0] digs[NDIG];
    int nd;
    text_char_t c;
    if (!symbol_set_ok()) return;
    mag = raw[WORD_W-1] ? -raw : raw;
    nd = 0;
    do begin
      digs[nd] = symbol_of(mag % cur_len);
      mag = mag / cur_len;
      nd++;
    end while (mag != 0 && nd < NDIG);
    if (raw[WORD_W-1]) begin
      c.ch = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch = digs[k];
      c.last = (k == 0);
      expected_text.push_back(c);
    end
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  // input driver, one word per handshake
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (values_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_value <= values_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) predict_radix_text(in_value);
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          flag_error($sformatf("unexpected word char=%0d last=%0b", out_character, out_last));
        end else begin
          want = expected_text.pop_front();
          if (want.ch != out_character || want.last != out_last)
            flag_error($sformatf("expected char=%0d last=%0b, got char=%0d last=%0b",
                                 want.ch, want.last, out_character, out_last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SYM_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_BASE_LENGTH:  cur_len = data[LEN_W-1:0];
      REG_SYMBOLS_LOW:  cur_low = data;
      REG_SYMBOLS_HIGH: cur_high = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // length word with junk in the bits above the register
  function automatic logic [SYM_W-1:0] len_word(input int unsigned n);
    logic [SYM_W-1:0] w;
    w = {$urandom, $urandom};
    w[LEN_W-1:0] = LEN_W'(n);
    return w;
  endfunction

  // hold off until everything sent has been converted and read out
  task automatic drain();
    while (values_to_send.size() != 0 || in_valid || expected_text.size() != 0)
      @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] random_value();
    case ($urandom_range(9))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return $urandom_range(40);
      3: return -$urandom_range(40);
      default: return $urandom;
    endcase
  endfunction

  // random symbol table, sometimes with one flaw that disables output
  task automatic load_random_base(output bit usable);
    logic [2*SYM_W-1:0] syms;
    logic [CHAR_W-1:0] s;
    bit taken[256];
    int unsigned n, k, r;
    base_flaw_t flaw;
    n = $urandom_range(MAX_BASE, 2);
    syms = {$urandom, $urandom, $urandom, $urandom};
    for (k = 0; k < n; k++) begin
      do s = CHAR_W'($urandom_range(127, SYM_MIN)); while (taken[s]);
      taken[s] = 1'b1;
      syms[k*CHAR_W +: CHAR_W] = s;
    end
    r = $urandom_range(11);
    flaw = (r < FLAW_NONE) ? base_flaw_t'(r) : FLAW_NONE;
    case (flaw)
      FLAW_SHORT:    n = $urandom_range(1);
      FLAW_LONG:     n = $urandom_range(31, MAX_BASE + 1);
      FLAW_LOW_SYM:
        syms[$urandom_range(n - 1)*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(SYM_MIN - 1));
      FLAW_HIGH_SYM:
        syms[$urandom_range(n - 1)*CHAR_W +: CHAR_W] = CHAR_W'($urandom_range(255, 128));
      FLAW_REPEAT: begin
        k = $urandom_range(n - 1, 1);
        syms[k*CHAR_W +: CHAR_W] = syms[$urandom_range(k - 1)*CHAR_W +: CHAR_W];
      end
      default: ;
    endcase
    write_reg(REG_BASE_LENGTH, len_word(n));
    write_reg(REG_SYMBOLS_LOW, syms[SYM_W-1:0]);
    write_reg(REG_SYMBOLS_HIGH, syms[2*SYM_W-1:SYM_W]);
    usable = symbol_set_ok();
  endtask

  initial begin
    int sent;
    bit usable;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset table, radix 10
    values_to_send = '{32'd0, 32'd1, -32'sd1, INT_MAX, INT_MIN};
    drain();

    // a write to the spare index must leave the table alone
    write_reg(REG_UNUSED, '1);
    values_to_send.push_back(32'h5555_5555);
    drain();

    // radix 2 with the lowest and highest legal symbols, junk in unused slots
    write_reg(REG_BASE_LENGTH, len_word(2));
    write_reg(REG_SYMBOLS_LOW, 64'hFFFF_FFFF_FFFF_7F30);
    write_reg(REG_SYMBOLS_HIGH, {$urandom, $urandom});
    values_to_send = '{INT_MIN, -32'sd1, 32'd0, INT_MAX};
    drain();

    // radix 16, full table
    write_reg(REG_BASE_LENGTH, len_word(MAX_BASE));
    write_reg(REG_SYMBOLS_LOW, HEX_LOW);
    write_reg(REG_SYMBOLS_HIGH, HEX_HIGH);
    values_to_send = '{INT_MIN, 32'h89AB_CDEF, 32'd15, -32'sd16};
    drain();

    // bad radix values: nothing may come out
    write_reg(REG_BASE_LENGTH, len_word(0));
    values_to_send.push_back(-32'sd12345);
    drain();
    write_reg(REG_BASE_LENGTH, len_word(1));
    values_to_send.push_back(-32'sd12345);
    drain();
    write_reg(REG_BASE_LENGTH, len_word(MAX_BASE + 1));
    values_to_send.push_back(-32'sd12345);
    drain();
    write_reg(REG_BASE_LENGTH, len_word(31));
    values_to_send.push_back(-32'sd12345);
    drain();

    // bad symbols: below '0', above 127, repeated
    write_reg(REG_BASE_LENGTH, len_word(MAX_BASE));
    write_reg(REG_SYMBOLS_HIGH, {SYM_TOO_LOW, HEX_HIGH[SYM_W-CHAR_W-1:0]});
    values_to_send.push_back(32'd77);
    drain();
    write_reg(REG_SYMBOLS_HIGH, HEX_HIGH);
    write_reg(REG_SYMBOLS_LOW, {HEX_LOW[SYM_W-1:4*CHAR_W], SYM_TOO_HIGH, HEX_LOW[3*CHAR_W-1:0]});
    values_to_send.push_back(32'd77);
    drain();
    write_reg(REG_SYMBOLS_LOW, HEX_LOW);
    write_reg(REG_SYMBOLS_HIGH, {HEX_HIGH[SYM_W-1:2*CHAR_W], HEX_LOW[3*CHAR_W-1:2*CHAR_W],
                                 HEX_HIGH[CHAR_W-1:0]});
    values_to_send.push_back(32'd77);
    drain();

    // random tables and values, idling pattern changes by thirds
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 51;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_random_base(usable);
      repeat (usable ? ITEMS_PER_BASE : ITEMS_BAD_BASE)
        values_to_send.push_back(random_value());
      sent += usable ? ITEMS_PER_BASE : ITEMS_BAD_BASE;
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### signed_integer_to_radix_digits_top.f
+incdir+src
src/sird_pkg.sv
src/sird_ctrl.sv
src/sird_dp.sv
src/signed_integer_to_radix_digits_top.sv
src/sird_checker.sv
tb/tb.sv
